FILE: src/fmbq_pkg.sv
// Shared types and constants of the front/middle/back queue.
package fmbq_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountOutWidth = 5;
  localparam logic [ValueWidth-1:0] PopEmptyValue = '1;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT  = 3'd0,
    CMD_PUSH_MIDDLE = 3'd1,
    CMD_PUSH_BACK   = 3'd2,
    CMD_POP_FRONT   = 3'd3,
    CMD_POP_MIDDLE  = 3'd4,
    CMD_POP_BACK    = 3'd5
  } fmbq_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } fmbq_status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_PUSH_RD,
    DP_PUSH_WR,
    DP_PUSH_PUT,
    DP_POP_RD,
    DP_POP_CAP,
    DP_POP_RD_NEXT,
    DP_POP_WR,
    DP_POP_DONE,
    DP_OUT
  } fmbq_op_e;

  typedef struct packed {
    fmbq_op_e op;
  } fmbq_ctrl_t;

  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic bypass;
    logic at_pos;
    logic at_end;
  } fmbq_stat_t;

endpackage

FILE: src/fmbq_datapath.sv
// Datapath of the queue: entry memory, count, cursor and result registers.
module fmbq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fmbq_pkg::fmbq_ctrl_t     ctrl_i,
  output fmbq_pkg::fmbq_stat_t     stat_o,
  input  logic [2:0]               command_i,
  input  logic [31:0]              push_value_i,
  output logic [31:0]              pop_value_o,
  output fmbq_pkg::fmbq_status_e   status_o,
  output logic [4:0]               entry_count_o
);
  import fmbq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [ValueWidth-1:0] mem [CAPACITY];
  logic [ValueWidth-1:0] rd_data_q;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ValueWidth-1:0] wr_data;

  logic [CW-1:0]         count_q, count_d;
  logic [2:0]            cmd_q;
  logic [ValueWidth-1:0] val_q;
  fmbq_status_e          status_q, status_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [ValueWidth-1:0] popped_q, popped_d;
  logic [ValueWidth-1:0] out_value_q;
  fmbq_status_e          out_status_q;
  logic [CW-1:0]         out_count_q;
  logic [CW+CountOutWidth-1:0] out_count_ext;

  logic          in_push, in_pop, cmd_push, cmd_pop;
  logic [CW-1:0] half;

  assign in_push  = (command_i <= CMD_PUSH_BACK);
  assign in_pop   = (command_i >= CMD_POP_FRONT) && (command_i <= CMD_POP_BACK);
  assign cmd_push = (cmd_q <= CMD_PUSH_BACK);
  assign cmd_pop  = (cmd_q >= CMD_POP_FRONT) && (cmd_q <= CMD_POP_BACK);
  assign half     = count_q >> 1;

  // Decode a command against the fill level; step cursor, count, popped.
  always_comb begin
    status_d = status_q;
    pos_d    = pos_q;
    cur_d    = cur_q;
    popped_d = popped_q;
    count_d  = count_q;
    case (ctrl_i.op)
      DP_LOAD: begin
        status_d = ST_DONE;
        popped_d = '0;
        pos_d    = '0;
        if (in_push) begin
          if (count_q == CW'(CAPACITY)) begin
            status_d = ST_FULL;
          end
          case (command_i)
            CMD_PUSH_MIDDLE: pos_d = AW'(half);
            CMD_PUSH_BACK:   pos_d = AW'(count_q);
            default:         pos_d = '0;
          endcase
          cur_d = AW'(count_q);
        end else if (in_pop) begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
            popped_d = PopEmptyValue;
          end
          case (command_i)
            CMD_POP_MIDDLE: pos_d = count_q[0] ? AW'(half) : AW'(half - CW'(1));
            CMD_POP_BACK:   pos_d = AW'(count_q - CW'(1));
            default:        pos_d = '0;
          endcase
          cur_d = pos_d;
        end
      end
      DP_PUSH_WR:  cur_d = cur_q - AW'(1);
      DP_PUSH_PUT: count_d = count_q + CW'(1);
      DP_POP_CAP:  popped_d = rd_data_q;
      DP_POP_WR:   cur_d = cur_q + AW'(1);
      DP_POP_DONE: count_d = count_q - CW'(1);
      default: ;
    endcase
  end

  // Memory port selection: one read and one write per cycle at most.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q;
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = rd_data_q;
    case (ctrl_i.op)
      DP_PUSH_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_q - AW'(1);
      end
      DP_PUSH_WR: wr_en = 1'b1;
      DP_PUSH_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = val_q;
      end
      DP_POP_RD: begin
        rd_en   = 1'b1;
        rd_addr = pos_q;
      end
      DP_POP_RD_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = cur_q + AW'(1);
      end
      DP_POP_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
    cur_q    <= cur_d;
    popped_q <= popped_d;
    if (ctrl_i.op == DP_LOAD) begin
      cmd_q <= command_i;
      val_q <= push_value_i;
    end
    if (ctrl_i.op == DP_OUT) begin
      out_value_q  <= popped_q;
      out_status_q <= status_q;
      out_count_q  <= count_q;
    end
  end

  assign stat_o.is_push = cmd_push;
  assign stat_o.is_pop  = cmd_pop;
  assign stat_o.bypass  = (status_q != ST_DONE) || !(cmd_push || cmd_pop);
  assign stat_o.at_pos  = (cur_q == pos_q);
  assign stat_o.at_end  = ((CW'(cur_q) + CW'(1)) == count_q);

  assign out_count_ext = {{CountOutWidth{1'b0}}, out_count_q};
  assign pop_value_o   = out_value_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_ext[CountOutWidth-1:0];

  // Fill level moves by one step at most per cycle.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
    else $error("count jumped by more than one");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("count above capacity");

  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == DP_PUSH_PUT) |-> (count_q < CW'(CAPACITY) && status_q == ST_DONE))
    else $error("insert into a full queue");

  a_drop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == DP_POP_DONE) |-> (count_q != '0 && status_q == ST_DONE))
    else $error("removal from an empty queue");

endmodule

FILE: src/fmbq_ctrl.sv
// Controller state machine that sequences the entry moves of each command.
module fmbq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fmbq_pkg::fmbq_ctrl_t ctrl_o,
  input  fmbq_pkg::fmbq_stat_t stat_i
);
  import fmbq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_PUSH_CHK,
    S_PUSH_WR,
    S_POP_RD,
    S_POP_CAP,
    S_POP_CHK,
    S_POP_WR,
    S_FINISH
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  fmbq_op_e op;
  logic     out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    op          = DP_NOP;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = DP_LOAD;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.bypass) begin
          state_d = S_FINISH;
        end else if (stat_i.is_push) begin
          state_d = S_PUSH_CHK;
        end else if (stat_i.is_pop) begin
          state_d = S_POP_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_PUSH_CHK: begin
        if (stat_i.at_pos) begin
          op      = DP_PUSH_PUT;
          state_d = S_FINISH;
        end else begin
          op      = DP_PUSH_RD;
          state_d = S_PUSH_WR;
        end
      end
      S_PUSH_WR: begin
        op      = DP_PUSH_WR;
        state_d = S_PUSH_CHK;
      end
      S_POP_RD: begin
        op      = DP_POP_RD;
        state_d = S_POP_CAP;
      end
      S_POP_CAP: begin
        op      = DP_POP_CAP;
        state_d = S_POP_CHK;
      end
      S_POP_CHK: begin
        if (stat_i.at_end) begin
          op      = DP_POP_DONE;
          state_d = S_FINISH;
        end else begin
          op      = DP_POP_RD_NEXT;
          state_d = S_POP_WR;
        end
      end
      S_POP_WR: begin
        op      = DP_POP_WR;
        state_d = S_POP_CHK;
      end
      S_FINISH: begin
        if (out_free) begin
          op          = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ctrl_o.op   = op;

  // A result word is only published on the way back to idle.
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FINISH && state_q == S_IDLE))
    else $error("result published outside the finish step");

  a_finish_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == DP_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == DP_LOAD) |=> (state_q == S_DECIDE))
    else $error("accepted command not decoded");

endmodule

FILE: src/front_middle_back_queue_core.sv
// Top level of the front/middle/back queue: controller plus datapath.
//
// Usage: each word on the slave stream is one command. tuser carries the
// command code (push front, push middle, push back, pop front, pop middle,
// pop back); tdata carries the value to push. Every command returns exactly
// one word on the master stream: tdata holds the popped value and the entry
// count after the command, tuser holds the status (done, pop on empty, push
// dropped because full). A pop on an empty queue returns all ones.
// A push moves every entry at or above the insert position pos one place
// back; a pop moves every entry behind the removal position one place
// forward. A dropped push, an empty pop or an unused code moves no entry.
// Entries move one at a time through the entry memory with one read port
// and one write port: each entry moved to open or close the gap is read
// and then written back. One command is in work at a time; the next is
// accepted once the result is registered, even while that result still
// waits for the receiver.
// A stalled receiver holds the result word stable; a finished command then
// waits in its last step until the output register frees up.
// Reset empties the queue at once (count cleared); entry contents are not
// cleared and are only read below the count.
module front_middle_back_queue_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [2:0]  s_axis_tuser,   // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] pop_value, [36:32] entry_count, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import fmbq_pkg::*;

  fmbq_ctrl_t   ctrl;
  fmbq_stat_t   stat;
  logic [31:0]  pop_value;
  fmbq_status_e status;
  logic [4:0]   entry_count;

  // Sequence each command: decode, move entries, publish the result.
  fmbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  // Hold the entries and the count; shift entries one at a time, each read and then written back.
  fmbq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .command_i     (s_axis_tuser),
    .push_value_i  (s_axis_tdata),
    .pop_value_o   (pop_value),
    .status_o      (status),
    .entry_count_o (entry_count)
  );

  // Pack the result word, low field first, padded to whole bytes.
  assign m_axis_tdata = {3'b000, entry_count, pop_value};
  assign m_axis_tuser = status;

endmodule
